### design/lru_voice_allocator_defines.svh
// ----------------------------------------------------------------------------
// lru_voice_allocator_defines.svh
// Assertion macros used by the voice allocator checker.
// ----------------------------------------------------------------------------
`ifndef LRU_VOICE_ALLOCATOR_DEFINES_SVH
`define LRU_VOICE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define VLA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define VLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/vla_pkg.sv
// ----------------------------------------------------------------------------
// vla_pkg
// Shared widths, command and event codes, and the queued word type.
// ----------------------------------------------------------------------------
package vla_pkg;

   localparam int CH_MAX = 16;
   localparam int CH_W   = 4;
   localparam int CNT_W  = 5;
   localparam int NOTE_W = 16;
   localparam int KIND_W = 2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STOP  = 1'b1;

   localparam logic [KIND_W-1:0] EV_START_FREE  = 2'd0;
   localparam logic [KIND_W-1:0] EV_START_STEAL = 2'd1;
   localparam logic [KIND_W-1:0] EV_STOPPED     = 2'd2;
   localparam logic [KIND_W-1:0] EV_STOP_MISS   = 2'd3;

   typedef struct packed {
      logic              is_stop;
      logic [NOTE_W-1:0] note;
   } work_type;

endpackage

### design/vla_front.sv
// ----------------------------------------------------------------------------
// vla_front
// Request intake: classifies each command word and holds it in a 2-entry queue.
// ----------------------------------------------------------------------------
module vla_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [15:0]           req_note_value,
   output logic                  q_valid,
   input  logic                  q_pop,
   output vla_pkg::work_type     q_word
);
   import vla_pkg::*;

   work_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   work_type   word_new;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_word    = mem_ff[rd_ptr_ff];

   always_comb begin
      word_new.is_stop = (req_command == CMD_STOP);
      word_new.note    = req_note_value;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= word_new;
      end
   end

endmodule

### design/vla_engine.sv
// ----------------------------------------------------------------------------
// vla_engine
// Channel list sequencer: start/steal in one step, stop by scanning held notes
// and then the sounding list, with a registered result word.
// ----------------------------------------------------------------------------
module vla_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  vla_pkg::work_type     q_word,
   output logic                  q_pop,
   input  logic                  csr_write_enable,
   input  logic [4:0]            csr_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_channel,
   output logic [1:0]            rsp_event_kind,
   output logic [15:0]           rsp_note_out
);
   import vla_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE       = 4'b0001,
      ST_SCAN_NOTE  = 4'b0010,
      ST_SCAN_SOUND = 4'b0100,
      ST_REMOVE     = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  active_ff, active_in;
   logic [CH_W-1:0]   free_ff [CH_MAX];
   logic [CH_W-1:0]   free_in [CH_MAX];
   logic [CH_W-1:0]   so_ff [CH_MAX];
   logic [CH_W-1:0]   so_in [CH_MAX];
   logic [NOTE_W-1:0] held_ff [CH_MAX];
   logic [NOTE_W-1:0] held_in [CH_MAX];
   logic [CNT_W-1:0]  fcount_ff, fcount_in;
   logic [CNT_W-1:0]  scount_ff, scount_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [CH_W-1:0]   idx_ff, idx_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]   rsp_channel_ff, rsp_channel_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [NOTE_W-1:0] rsp_note_ff, rsp_note_in;
   logic              out_free;
   logic [CNT_W-1:0]  scount_m1;
   logic [CNT_W-1:0]  active_m1;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (n == '0) r = CNT_W'(1);
      if (n > CNT_W'(CH_MAX)) r = CNT_W'(CH_MAX);
      return r;
   endfunction

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign scount_m1      = scount_ff - CNT_W'(1);
   assign active_m1      = active_ff - CNT_W'(1);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_note_out   = rsp_note_ff;

   always_comb begin
      logic [CH_W-1:0] pick;
      pick           = '0;
      state_in       = state_ff;
      active_in      = active_ff;
      free_in        = free_ff;
      so_in          = so_ff;
      held_in        = held_ff;
      fcount_in      = fcount_ff;
      scount_in      = scount_ff;
      note_in        = note_ff;
      idx_in         = idx_ff;
      ch_in          = ch_ff;
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_channel_in = rsp_channel_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_note_in    = rsp_note_ff;
      q_pop          = 1'b0;

      if (csr_write_enable) begin
         // any count write rebuilds the lists: all free, ascending
         active_in = clamp_count(csr_write_data);
         fcount_in = clamp_count(csr_write_data);
         scount_in = '0;
         for (int i = 0; i < CH_MAX; i++) begin
            free_in[i] = CH_W'(i);
            held_in[i] = '0;
         end
         state_in = ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid && out_free) begin
                  q_pop = 1'b1;
                  if (q_word.is_stop) begin
                     note_in  = q_word.note;
                     idx_in   = '0;
                     state_in = ST_SCAN_NOTE;
                  end else begin
                     if (fcount_ff != '0) begin
                        pick = free_ff[0];
                        for (int i = 0; i < CH_MAX - 1; i++) begin
                           free_in[i] = free_ff[i+1];
                        end
                        fcount_in = fcount_ff - CNT_W'(1);
                        if (scount_ff < CNT_W'(CH_MAX)) begin
                           so_in[scount_ff[CH_W-1:0]] = pick;
                           scount_in = scount_ff + CNT_W'(1);
                        end
                        rsp_kind_in = EV_START_FREE;
                     end else if (scount_ff != '0) begin
                        // steal the oldest sounding channel, requeue it last
                        pick = so_ff[0];
                        for (int i = 0; i < CH_MAX - 1; i++) begin
                           so_in[i] = so_ff[i+1];
                        end
                        so_in[scount_m1[CH_W-1:0]] = pick;
                        rsp_kind_in = EV_START_STEAL;
                     end else begin
                        rsp_kind_in = EV_START_STEAL;
                     end
                     held_in[pick]  = q_word.note;
                     rsp_valid_in   = 1'b1;
                     rsp_channel_in = pick;
                     rsp_note_in    = q_word.note;
                  end
               end
            end
            ST_SCAN_NOTE: begin
               if (held_ff[idx_ff] == note_ff) begin
                  ch_in    = idx_ff;
                  pos_in   = '0;
                  state_in = ST_SCAN_SOUND;
               end else if ({1'b0, idx_ff} == active_m1) begin
                  rsp_valid_in   = 1'b1;
                  rsp_channel_in = '0;
                  rsp_kind_in    = EV_STOP_MISS;
                  rsp_note_in    = '0;
                  state_in       = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CH_W'(1);
               end
            end
            ST_SCAN_SOUND: begin
               if (pos_ff < scount_ff) begin
                  if (so_ff[pos_ff[CH_W-1:0]] == ch_ff) begin
                     state_in = ST_REMOVE;
                  end else begin
                     pos_in = pos_ff + CNT_W'(1);
                  end
               end else begin
                  // lowest match is already free
                  rsp_valid_in   = 1'b1;
                  rsp_channel_in = '0;
                  rsp_kind_in    = EV_STOP_MISS;
                  rsp_note_in    = '0;
                  state_in       = ST_IDLE;
               end
            end
            ST_REMOVE: begin
               for (int i = 0; i < CH_MAX - 1; i++) begin
                  if (CNT_W'(i) >= pos_ff) begin
                     so_in[i] = so_ff[i+1];
                  end
               end
               scount_in = scount_m1;
               if (fcount_ff < CNT_W'(CH_MAX)) begin
                  free_in[fcount_ff[CH_W-1:0]] = ch_ff;
                  fcount_in = fcount_ff + CNT_W'(1);
               end
               rsp_valid_in   = 1'b1;
               rsp_channel_in = ch_ff;
               rsp_kind_in    = EV_STOPPED;
               rsp_note_in    = note_ff;
               state_in       = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= CNT_W'(1);
         fcount_ff    <= CNT_W'(1);
         scount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CH_MAX; i++) begin
            free_ff[i] <= CH_W'(i);
            held_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         fcount_ff    <= fcount_in;
         scount_ff    <= scount_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      so_ff          <= so_in;
      note_ff        <= note_in;
      idx_ff         <= idx_in;
      ch_ff          <= ch_in;
      pos_ff         <= pos_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_note_ff    <= rsp_note_in;
   end

endmodule

### design/lru_voice_allocator.sv
// ----------------------------------------------------------------------------
// lru_voice_allocator
// Polyphonic voice allocator, oldest-free first, oldest-sounding stolen.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one command word per handshake (start or stop, 16-bit note).
//   rsp_*  : one result word per command: channel, event kind, note held.
//   csr_*  : active channel count write; rebuilds all lists, so the user must
//            do it only while no command is in flight; it is not enforced.
// Sequence and throughput:
//   A word sits in a 2-entry intake queue, then the sequencer takes it.
//   Start: registered result, one start per cycle while no result is stalled.
//   Stop: the held-note scan checks channels in ascending order up to the
//   first match (at most active_channels), then the sounding-list scan
//   checks entries up to the hit, and a last step unlinks it; the
//   sequencer takes no new word until the stop result is produced.
// Reset: one active channel, free, holding note 0; nothing queued.
// Stall: a stalled result holds in the output register; the sequencer
//   waits, the queue fills, and req_stall rises once two words are queued.
// ----------------------------------------------------------------------------
module lru_voice_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_note_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel,
   output logic [1:0]  rsp_event_kind,
   output logic [15:0] rsp_note_out,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data
);
   import vla_pkg::*;

   logic     q_valid;
   logic     q_pop;
   work_type q_word;

   vla_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_note_value (req_note_value),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_word         (q_word)
   );

   vla_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_word           (q_word),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel      (rsp_channel),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_note_out     (rsp_note_out)
   );

endmodule

### design/vla_checker.sv
// ----------------------------------------------------------------------------
// vla_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_voice_allocator_defines.svh"

module vla_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_command,
   input logic [15:0] req_note_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_channel,
   input logic [1:0]  rsp_event_kind,
   input logic [15:0] rsp_note_out,
   input logic        csr_write_enable,
   input logic [4:0]  csr_write_data
);
   import vla_pkg::*;

   logic req_word_seen;
   assign req_word_seen = req_valid && !req_stall && (req_command || !req_command)
                          && (req_note_value == req_note_value)
                          && (csr_write_enable || !csr_write_enable)
                          && (csr_write_data == csr_write_data);

   // a result waiting on the receiver keeps its word
   `VLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_channel) && $stable(rsp_event_kind) && $stable(rsp_note_out),
      "stalled result word changed")

   // a missed stop reports channel 0 and note 0
   `VLA_ASSERT_NOW(a_miss_zero, rsp_valid && (rsp_event_kind == EV_STOP_MISS),
      (rsp_channel == 4'd0) && (rsp_note_out == 16'd0),
      "stop miss with nonzero fields")

   // leaving reset: no result pending, queue empty
   `VLA_ASSERT_NOW(a_reset_rsp, $past(reset), !rsp_valid,
      "result valid right after reset")
   `VLA_ASSERT_NOW(a_reset_req, $past(reset) || ($past(reset, 2) && !$past(req_word_seen)),
      !req_stall, "intake stalled right after reset")

endmodule

bind lru_voice_allocator vla_checker u_vla_checker (.*);
